[design/hps_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and rounding helper for the height-field shader.
// No dependencies; used by every module of the shader core.
package hps_pkg;

  localparam int CW        = 25;    // raw vector component width (signed Q16.8 difference)
  localparam int UW        = 32;    // unit vector component width (signed Q.30)
  localparam int QB        = 30;    // fraction bits of a unit component
  localparam int SQ_N      = 31;    // square root stages, one result bit each
  localparam int DV_N      = 31;    // divider stages, one quotient bit each
  localparam int COORD_MAX = 4096;

  localparam int IN_W    = 144;
  localparam int OUT_W   = 16;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 24;

  // 0.98 in Q.30, and the reflection clamp of 1.5 in Q.30.
  localparam logic [31:0] THRESH_Q30 = 32'd1052266988;
  localparam logic [31:0] REFL_LIM   = 32'd1610612736;
  // ceil(2^21 / 3): exact division by three for dividends below 2^21.
  localparam logic [19:0] RECIP3     = 20'd699051;

  typedef enum logic [CFG_IW-1:0] {
    CFG_SPEC_MODE = 3'd0,
    CFG_LIGHT_X   = 3'd1,
    CFG_LIGHT_Y   = 3'd2,
    CFG_LIGHT_Z   = 3'd3,
    CFG_EYE_X     = 3'd4,
    CFG_EYE_Y     = 3'd5,
    CFG_EYE_Z     = 3'd6
  } cfg_idx_t;

  typedef logic signed [CW-1:0] comp_t;
  typedef comp_t cvec_t [3];
  typedef logic signed [UW-1:0] ucomp_t;
  typedef ucomp_t uvec_t [3];

  typedef struct packed {
    logic vld;
    logic zero;
  } norm_stat_t;

  // v / 2^s, rounded half away from zero.
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned s);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

endpackage

[design/heightfield_phong_shader_core.sv]
`timescale 1ns / 1ps
// Top level of the height-field shader: configuration registers, vector setup,
// three normalizers, shading pipeline and output skid. Depends on hps_pkg.
//
//   channel   | dir | payload (low bit first)
//   s_axis    | in  | pos_x, pos_y, height_center, left, right, up, down
//   m_axis    | out | shade (signed Q2.14)
//   cfg       | in  | specular_mode, light_x/y/z, eye_x/y/z by index
//
// One pixel word is accepted per clock while the skid word is empty; the whole
// datapath is pipelined, and most of its depth lies in the 31-stage square root
// and the 31-stage dividers of the normalizers.
// Reset is synchronous; it clears valid bits and configuration registers.
// A stall on m_axis freezes every stage once the skid word is occupied.
module heightfield_phong_shader_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // pos_x, pos_y, height_center, height_left, height_right, height_up, height_down
  input  logic [hps_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // shade
  output logic [hps_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                         cfg_we,
  input  logic [hps_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [hps_pkg::CFG_DW-1:0]   cfg_data
);
  import hps_pkg::*;

  logic        spec_mode;
  logic [23:0] light_x, light_y, light_z;
  logic [23:0] eye_x, eye_y, eye_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      spec_mode <= 1'b0;
      light_x   <= '0;
      light_y   <= '0;
      light_z   <= '0;
      eye_x     <= '0;
      eye_y     <= '0;
      eye_z     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SPEC_MODE: spec_mode <= cfg_data[0];
        CFG_LIGHT_X:   light_x   <= cfg_data;
        CFG_LIGHT_Y:   light_y   <= cfg_data;
        CFG_LIGHT_Z:   light_z   <= cfg_data;
        CFG_EYE_X:     eye_x     <= cfg_data;
        CFG_EYE_Y:     eye_y     <= cfg_data;
        CFG_EYE_Z:     eye_z     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;

  logic [11:0] px, py, px_s, py_s;
  logic [23:0] hc, hl, hr, hu, hd;
  logic [19:0] xq, yq;
  cvec_t       nv_c, lv_c, ev_c;

  assign px = s_axis_tdata[11:0];
  assign py = s_axis_tdata[23:12];
  assign hc = s_axis_tdata[47:24];
  assign hl = s_axis_tdata[71:48];
  assign hr = s_axis_tdata[95:72];
  assign hu = s_axis_tdata[119:96];
  assign hd = s_axis_tdata[143:120];

  always_comb begin
    px_s = ({20'b0, px} > 32'(COORD_MAX - 1)) ? 12'(COORD_MAX - 1) : px;
    py_s = ({20'b0, py} > 32'(COORD_MAX - 1)) ? 12'(COORD_MAX - 1) : py;
    xq   = {px_s, 8'b0};
    yq   = {py_s, 8'b0};
    // The normal is scaled by 512 so that it stays exact in Q16.8.
    nv_c[0] = {hl[23], hl} - {hr[23], hr};
    nv_c[1] = {hu[23], hu} - {hd[23], hd};
    nv_c[2] = CW'(512);
    lv_c[0] = {light_x[23], light_x} - {5'b0, xq};
    lv_c[1] = {light_y[23], light_y} - {5'b0, yq};
    lv_c[2] = {light_z[23], light_z} - {hc[23], hc};
    ev_c[0] = {5'b0, xq} - {eye_x[23], eye_x};
    ev_c[1] = {5'b0, yq} - {eye_y[23], eye_y};
    ev_c[2] = {hc[23], hc} - {eye_z[23], eye_z};
  end

  logic  s0_vld;
  cvec_t s0_nv, s0_lv, s0_ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_nv <= nv_c;
      s0_lv <= lv_c;
      s0_ev <= ev_c;
    end
  end

  assign s_axis_tready = en;

  norm_stat_t n_stat, l_stat, e_stat;
  uvec_t      n_u, l_u, e_u;

  hps_norm u_norm_n (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s0_vld),
    .in_c     (s0_nv),
    .out_stat (n_stat),
    .out_u    (n_u)
  );

  hps_norm u_norm_l (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s0_vld),
    .in_c     (s0_lv),
    .out_stat (l_stat),
    .out_u    (l_u)
  );

  hps_norm u_norm_e (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s0_vld),
    .in_c     (s0_ev),
    .out_stat (e_stat),
    .out_u    (e_u)
  );

  logic               sh_vld;
  logic signed [15:0] sh_val;

  hps_shade u_shade (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .spec_mode (spec_mode),
    .n_stat    (n_stat),
    .l_stat    (l_stat),
    .e_stat    (e_stat),
    .n_u       (n_u),
    .l_u       (l_u),
    .e_u       (e_u),
    .out_vld   (sh_vld),
    .out_shade (sh_val)
  );

  hps_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (sh_vld),
    .in_data  (sh_val),
    .advance  (en),
    .out_vld  (m_axis_tvalid),
    .out_rdy  (m_axis_tready),
    .out_data (m_axis_tdata)
  );

endmodule

[design/hps_norm.sv]
`timescale 1ns / 1ps
// Pipelined vector normalizer: block shift, sum of squares, bit-serial square
// root and three restoring dividers. Depends on hps_pkg.
module hps_norm (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  hps_pkg::cvec_t      in_c,
  output hps_pkg::norm_stat_t out_stat,
  output hps_pkg::uvec_t      out_u
);
  import hps_pkg::*;

  localparam int NLAT = 7 + SQ_N + DV_N;

  logic [NLAT-1:0] vpipe;
  logic [NLAT-1:0] zpipe;
  logic [2:0]      gpipe [NLAT-1];

  logic [CW-1:0] mag_c [3];
  logic [CW-1:0] max_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = in_c[i][CW-1] ? CW'(-in_c[i]) : CW'(in_c[i]);
    end
    max_c = mag_c[0];
    if (mag_c[1] > max_c) max_c = mag_c[1];
    if (mag_c[2] > max_c) max_c = mag_c[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[NLAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zpipe    <= {zpipe[NLAT-2:0], max_c == '0};
      gpipe[0] <= {in_c[2][CW-1], in_c[1][CW-1], in_c[0][CW-1]};
      for (int j = 1; j < NLAT - 1; j++) begin
        gpipe[j] <= gpipe[j-1];
      end
    end
  end

  // Stages 1 to 4: magnitudes, shift count, block shift, squares.
  logic [CW-1:0] s1_mag [3];
  logic [CW-1:0] s1_max;
  logic [CW-1:0] s2_mag [3];
  logic [4:0]    s2_k;
  logic [QB:0]   s3_vmag [3];
  logic [QB:0]   s4_vmag [3];
  logic [61:0]   s4_sq [3];

  // The shift is the largest k with max << k not above 2^30, which is
  // 30 minus the bit length of max - 1.
  logic [CW-1:0] mm1;
  logic [4:0]    blen;

  always_comb begin
    mm1  = s1_max - CW'(1);
    blen = '0;
    for (int i = 0; i < CW; i++) begin
      if (mm1[i]) blen = 5'(i + 1);
    end
  end

  // Square root pipeline: index 0 holds the sum of squares.
  logic [61:0] sq_cc   [0:SQ_N];
  logic [33:0] sq_rem  [0:SQ_N];
  logic [QB:0] sq_root [0:SQ_N];
  logic [QB:0] sq_vmag [0:SQ_N][3];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mag     <= mag_c;
      s1_max     <= max_c;
      s2_mag     <= s1_mag;
      s2_k       <= 5'(QB) - blen;
      for (int i = 0; i < 3; i++) begin
        s3_vmag[i] <= (QB+1)'(s2_mag[i]) << s2_k;
        s4_sq[i]   <= s3_vmag[i] * s3_vmag[i];
      end
      s4_vmag    <= s3_vmag;
      sq_cc[0]   <= s4_sq[0] + s4_sq[1] + s4_sq[2];
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_vmag[0] <= s4_vmag;
    end
  end

  for (genvar t = 1; t <= SQ_N; t++) begin : g_sq
    logic [33:0] rn;
    logic [33:0] trial;
    assign rn    = {sq_rem[t-1][31:0], sq_cc[t-1][61:60]};
    assign trial = {1'b0, sq_root[t-1], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        sq_cc[t]   <= sq_cc[t-1] << 2;
        sq_vmag[t] <= sq_vmag[t-1];
        if (rn >= trial) begin
          sq_rem[t]  <= rn - trial;
          sq_root[t] <= {sq_root[t-1][QB-1:0], 1'b1};
        end else begin
          sq_rem[t]  <= rn;
          sq_root[t] <= {sq_root[t-1][QB-1:0], 1'b0};
        end
      end
    end
  end

  // Divider pipeline: numerator is |v| * 2^30 + s/2, quotient has 31 bits,
  // so the partial remainder starts from the numerator's top 30 bits.
  logic [QB:0] dv_s  [0:DV_N];
  logic [QB:0] dv_r  [0:DV_N][3];
  logic [QB:0] dv_lo [0:DV_N][3];
  logic [QB:0] dv_q  [0:DV_N][3];

  for (genvar i = 0; i < 3; i++) begin : g_prep
    logic [60:0] num;
    assign num = {sq_vmag[SQ_N][i], {QB{1'b0}}} + 61'(sq_root[SQ_N][QB:1]);
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[0][i]  <= {1'b0, num[60:31]};
        dv_lo[0][i] <= num[30:0];
        dv_q[0][i]  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_s[0] <= sq_root[SQ_N];
    end
  end

  for (genvar t = 1; t <= DV_N; t++) begin : g_dv
    always_ff @(posedge clk) begin
      if (en) begin
        dv_s[t] <= dv_s[t-1];
      end
    end
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [QB+1:0] r2;
      assign r2 = {dv_r[t-1][i], dv_lo[t-1][i][QB]};
      always_ff @(posedge clk) begin
        if (en) begin
          dv_lo[t][i] <= dv_lo[t-1][i] << 1;
          if (r2 >= {1'b0, dv_s[t-1]}) begin
            dv_r[t][i] <= (QB+1)'(r2 - {1'b0, dv_s[t-1]});
            dv_q[t][i] <= {dv_q[t-1][i][QB-1:0], 1'b1};
          end else begin
            dv_r[t][i] <= r2[QB:0];
            dv_q[t][i] <= {dv_q[t-1][i][QB-1:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        out_u[i] <= gpipe[NLAT-2][i] ? -$signed({1'b0, dv_q[DV_N][i]})
                                     : $signed({1'b0, dv_q[DV_N][i]});
      end
    end
  end

  assign out_stat.vld  = vpipe[NLAT-1];
  assign out_stat.zero = zpipe[NLAT-1];

endmodule

[design/hps_shade.sv]
`timescale 1ns / 1ps
// Shading pipeline: diffuse dot product, eye reflection, highlight test and
// final scaling to Q2.14. Depends on hps_pkg.
module hps_shade (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     spec_mode,
  input  hps_pkg::norm_stat_t      n_stat,
  input  hps_pkg::norm_stat_t      l_stat,
  input  hps_pkg::norm_stat_t      e_stat,
  input  hps_pkg::uvec_t           n_u,
  input  hps_pkg::uvec_t           l_u,
  input  hps_pkg::uvec_t           e_u,
  output logic                     out_vld,
  output logic signed [15:0]       out_shade
);
  import hps_pkg::*;

  localparam logic signed [65:0] ONE60 = 66'sd1 <<< (2 * QB);
  localparam logic signed [63:0] ONE30 = 64'sd1 <<< QB;
  localparam logic signed [63:0] RLIM  = 64'($signed({1'b0, REFL_LIM}));
  localparam logic signed [65:0] THR   = $signed({4'b0, THRESH_Q30, {QB{1'b0}}});
  localparam logic signed [63:0] HALF  = 64'sd1 <<< (2 * QB - 1);
  localparam int                 SH    = 2 * QB - 14;
  localparam logic [63:0]        RND3  = 64'd3 << (SH - 1);

  logic [8:0] vpipe;
  logic [8:0] lzp;
  logic [7:0] ezp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[7:0], n_stat.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lzp <= {lzp[7:0], l_stat.zero};
      ezp <= {ezp[6:0], e_stat.zero};
    end
  end

  logic signed [63:0] p1_nl [3], p1_en [3];
  uvec_t              p1_n, p1_l, p1_e;
  logic signed [63:0] p2_diff, p2_ed;
  uvec_t              p2_n, p2_l, p2_e;
  logic signed [UW-1:0] p3_d;
  logic signed [63:0] p3_diff;
  uvec_t              p3_n, p3_l, p3_e;
  logic signed [63:0] p4_p [3];
  logic signed [63:0] p4_diff;
  uvec_t              p4_l, p4_e;
  uvec_t              p5_r, p5_l;
  logic signed [63:0] p5_diff;
  logic signed [63:0] p6_lr [3];
  logic signed [63:0] p6_diff;
  logic               p7_hl;
  logic signed [63:0] p7_diff;
  logic signed [16:0] p8_dsh;
  logic [16:0]        p8_t;
  logic               p8_neg;

  logic signed [65:0] snl, sen, slr;
  logic signed [63:0] dclamp, dr, dcl;
  logic signed [63:0] rs [3], rd [3];
  logic signed [63:0] ssum, two;
  logic [63:0]        tabs;
  logic [36:0]        qp;
  logic signed [17:0] sval, pick;

  always_comb begin
    snl = 66'(p1_nl[0]) + 66'(p1_nl[1]) + 66'(p1_nl[2]);
    sen = 66'(p1_en[0]) + 66'(p1_en[1]) + 66'(p1_en[2]);
    if (snl > ONE60) begin
      dclamp = 64'(ONE60);
    end else if (snl < -ONE60) begin
      dclamp = 64'(-ONE60);
    end else begin
      dclamp = 64'(snl);
    end
    dr = rnd_shr(p2_ed, QB);
    if (dr > ONE30) begin
      dcl = ONE30;
    end else if (dr < -ONE30) begin
      dcl = -ONE30;
    end else begin
      dcl = dr;
    end
    for (int i = 0; i < 3; i++) begin
      rs[i] = rnd_shr(p4_p[i], QB);
      rd[i] = 64'(p4_e[i]) - rs[i];
      if (rd[i] > RLIM) begin
        rd[i] = RLIM;
      end else if (rd[i] < -RLIM) begin
        rd[i] = -RLIM;
      end
    end
    slr  = 66'(p6_lr[0]) + 66'(p6_lr[1]) + 66'(p6_lr[2]);
    ssum = p7_hl ? p7_diff + HALF : p7_diff;
    two  = ssum <<< 1;
    tabs = two[63] ? 64'(-two) : 64'(two);
    tabs = tabs + RND3;
    // The shade is round(2 * sum / (3 * 2^46)): shift first, then divide by three.
    qp   = p8_t * RECIP3;
    sval = p8_neg ? -$signed({2'b0, qp[36:21]}) : $signed({2'b0, qp[36:21]});
    if (lzp[7]) begin
      pick = '0;
    end else if (!spec_mode) begin
      pick = 18'(p8_dsh);
    end else if (ezp[7]) begin
      pick = '0;
    end else begin
      pick = sval;
    end
    if (pick > 18'sd16384) begin
      pick = 18'sd16384;
    end else if (pick < -18'sd16384) begin
      pick = -18'sd16384;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_nl[i] <= n_u[i] * l_u[i];
        p1_en[i] <= e_u[i] * n_u[i];
        p4_p[i]  <= (p3_d * p3_n[i]) <<< 1;
        p5_r[i]  <= UW'(rd[i]);
        p6_lr[i] <= p5_l[i] * p5_r[i];
      end
      p1_n    <= n_u;
      p1_l    <= l_u;
      p1_e    <= e_u;
      p2_diff <= dclamp;
      p2_ed   <= 64'(sen);
      p2_n    <= p1_n;
      p2_l    <= p1_l;
      p2_e    <= p1_e;
      p3_d    <= UW'(dcl);
      p3_diff <= p2_diff;
      p3_n    <= p2_n;
      p3_l    <= p2_l;
      p3_e    <= p2_e;
      p4_diff <= p3_diff;
      p4_l    <= p3_l;
      p4_e    <= p3_e;
      p5_l    <= p4_l;
      p5_diff <= p4_diff;
      p6_diff <= p5_diff;
      p7_hl   <= slr > THR;
      p7_diff <= p6_diff;
      p8_dsh  <= 17'(rnd_shr(p7_diff, SH));
      p8_t    <= tabs[62:SH];
      p8_neg  <= two[63];
      out_shade <= 16'(pick);
    end
  end

  assign out_vld = vpipe[8];

  a_zero_light: assert property (@(posedge clk) disable iff (rst)
    out_vld && lzp[8] |-> out_shade == 16'sd0)
    else $error("shade not zero for a zero-length light vector");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> (out_shade <= 16'sd16384) && (out_shade >= -16'sd16384))
    else $error("shade outside of -1.0 to 1.0");

endmodule

[design/hps_skid.sv]
`timescale 1ns / 1ps
// Output register with a one-word skid stage; its ready gates the pipeline.
// Depends on hps_pkg for the word width.
module hps_skid (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_vld,
  input  logic [hps_pkg::OUT_W-1:0]   in_data,
  output logic                        advance,
  output logic                        out_vld,
  input  logic                        out_rdy,
  output logic [hps_pkg::OUT_W-1:0]   out_data
);
  import hps_pkg::*;

  logic             skid_vld;
  logic [OUT_W-1:0] skid_data;
  logic             in_fire;

  assign advance = !skid_vld;
  assign in_fire = in_vld && !skid_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (!out_vld || out_rdy) begin
      if (skid_vld) begin
        out_vld  <= 1'b1;
        skid_vld <= 1'b0;
      end else begin
        out_vld <= in_fire;
      end
    end else if (in_fire) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld || out_rdy) begin
      out_data <= skid_vld ? skid_data : in_data;
    end else if (in_fire) begin
      skid_data <= in_data;
    end
  end

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_vld)
    else $error("skid stage holds a word while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_vld) |-> $past(out_vld && !out_rdy))
    else $error("skid stage filled without an output stall");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for heightfield_phong_shader_core: directed and random pixel
// words under several light/eye settings, with random stalls on both streams.
// Depends on hps_pkg and the shader core RTL.
module testbench;
  import hps_pkg::*;

  localparam logic [CFG_IW-1:0] CFG_UNUSED = 3'd7;
  localparam int LATENCY = 80;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam longint ONE30 = 64'sd1 << 30;
  localparam longint ONE60 = 64'sd1 << 60;
  localparam longint RLIM = 64'sd3 << 29;

  typedef struct packed {
    logic signed [23:0] hd, hu, hr, hl, hc;
    logic [11:0] py, px;
  } pixel_t;

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, m_axis_tready = 0;
  logic s_axis_tready, m_axis_tvalid;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_we = 0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  heightfield_phong_shader_core uut (.*);

  always #10 clk = ~clk;

  // Shadow copy of the configuration registers.
  logic spec_mode;
  longint light_pt [3], eye_pt [3];

  logic [15:0] shade_q [$];
  int errors = 0, n_sent = 0, n_checked = 0, n_highlight = 0;
  longint cycles = 0;
  int hold_off = 0;
  bit rx_smooth = 0;

  // ---------------- predictor ----------------
  function automatic longint unsigned mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint shr_round(longint v, int s);
    longint unsigned m;
    m = (mag(v) + (64'd1 << (s - 1))) >> s;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint div_round(longint num, longint unsigned den);
    longint unsigned m;
    m = (mag(num) + den / 2) / den;
    return num < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scales the vector to unit length in Q.30; returns 0 for a zero vector.
  function automatic bit to_unit(input longint c [3], output longint u [3]);
    longint unsigned m, ss, s;
    longint v [3];
    int k;
    m = mag(c[0]);
    if (mag(c[1]) > m) m = mag(c[1]);
    if (mag(c[2]) > m) m = mag(c[2]);
    u = '{0, 0, 0};
    if (m == 0) return 0;
    k = 0;
    while ((m << (k + 1)) <= 64'(ONE30)) k++;
    ss = 0;
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'(mag(c[i]) << k);
      if (c[i] < 0) v[i] = -v[i];
      ss += 64'(v[i] * v[i]);
    end
    s = int_sqrt(ss);
    for (int i = 0; i < 3; i++) u[i] = div_round(v[i] * ONE30, s);
    return 1;
  endfunction

  function automatic longint dot3(longint a [3], longint b [3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic logic [15:0] shade_of(pixel_t p);
    longint x, y, d, sum, diffuse, shade;
    longint nv [3], lv [3], ev [3], n [3], l [3], e [3], r [3];
    x = longint'(p.px) << 8;
    y = longint'(p.py) << 8;
    nv = '{longint'(p.hl) - p.hr, longint'(p.hu) - p.hd, 512};
    lv = '{light_pt[0] - x, light_pt[1] - y, light_pt[2] - p.hc};
    ev = '{x - eye_pt[0], y - eye_pt[1], p.hc - eye_pt[2]};
    shade = 0;
    void'(to_unit(nv, n));
    if (to_unit(lv, l)) begin
      diffuse = clip(dot3(n, l), -ONE60, ONE60);
      if (!spec_mode) begin
        shade = shr_round(diffuse, 46);
      end else if (to_unit(ev, e)) begin
        d = clip(shr_round(dot3(e, n), 30), -ONE30, ONE30);
        sum = diffuse;
        for (int i = 0; i < 3; i++)
          r[i] = clip(e[i] - shr_round(2 * d * n[i], 30), -RLIM, RLIM);
        if (dot3(l, r) > longint'(THRESH_Q30) * ONE30) begin
          sum += 64'sd1 << 59;
          n_highlight++;
        end
        shade = div_round(2 * sum, 64'd3 << 46);
      end
    end
    return 16'(clip(shade, -16384, 16384));
  endfunction

  // ---------------- drivers ----------------
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_SPEC_MODE: spec_mode = val[0];
      CFG_LIGHT_X: light_pt[0] = longint'($signed(val));
      CFG_LIGHT_Y: light_pt[1] = longint'($signed(val));
      CFG_LIGHT_Z: light_pt[2] = longint'($signed(val));
      CFG_EYE_X: eye_pt[0] = longint'($signed(val));
      CFG_EYE_Y: eye_pt[1] = longint'($signed(val));
      CFG_EYE_Z: eye_pt[2] = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic set_scene(logic mode, logic [23:0] lx, ly, lz, ex, ey, ez);
    write_reg(CFG_SPEC_MODE, {23'd0, mode});
    write_reg(CFG_LIGHT_X, lx);
    write_reg(CFG_LIGHT_Y, ly);
    write_reg(CFG_LIGHT_Z, lz);
    write_reg(CFG_EYE_X, ex);
    write_reg(CFG_EYE_Y, ey);
    write_reg(CFG_EYE_Z, ez);
  endtask

  // Sends one pixel word; the word is taken at the edge after tready is seen high.
  task automatic send_pixel(pixel_t p, bit no_gap = 0);
    int g;
    s_axis_tvalid <= 1;
    s_axis_tdata <= p;
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    shade_q.push_back(shade_of(p));
    n_sent++;
    g = no_gap ? 0 : gap_len();
    if (g != 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (shade_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    int spread;
    p.px = 12'($urandom);
    p.py = 12'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      {p.hc, p.hl, p.hr, p.hu, p.hd} = 120'({$urandom, $urandom, $urandom, $urandom});
    end else begin
      // Smooth terrain: neighbors close to the center height.
      spread = 1 << $urandom_range(2, 12);
      p.hc = 24'($signed(24'($urandom_range(0, 1 << 17))) - (1 << 16));
      p.hl = 24'(p.hc + $signed(24'($urandom_range(0, 2 * spread))) - spread);
      p.hr = 24'(p.hc + $signed(24'($urandom_range(0, 2 * spread))) - spread);
      p.hu = 24'(p.hc + $signed(24'($urandom_range(0, 2 * spread))) - spread);
      p.hd = 24'(p.hc + $signed(24'($urandom_range(0, 2 * spread))) - spread);
    end
    return p;
  endfunction

  // ---------------- receiver and checker ----------------
  always @(posedge clk) begin
    if (hold_off > 0) begin
      m_axis_tready <= 0;
      hold_off <= hold_off - 1;
    end else if (rx_smooth) begin
      m_axis_tready <= 1;
    end else begin
      m_axis_tready <= $urandom_range(0, 99) < 75;
      if ($urandom_range(0, 499) == 0) hold_off <= $urandom_range(10, 60);
    end
  end

  task automatic report(string what, logic [15:0] want, logic [15:0] got);
    $display("mismatch (%s): expected shade %0d, got %0d", what,
             $signed(want), $signed(got));
    errors++;
  endtask

  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (shade_q.size() == 0) begin
        report("unexpected word", 16'd0, m_axis_tdata);
      end else begin
        if (shade_q[0] !== m_axis_tdata) report("shade", shade_q[0], m_axis_tdata);
        void'(shade_q.pop_front());
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------- tests ----------------
  function automatic pixel_t flat(logic [11:0] x, y, logic signed [23:0] h);
    return '{hd: h, hu: h, hr: h, hl: h, hc: h, py: y, px: x};
  endfunction

  task automatic test_reset_state();
    // All registers zero: the light sits on pixel (0,0) at height 0.
    send_pixel(flat(12'd0, 12'd0, 24'sd0));
    send_pixel(flat(12'd0, 12'd0, 24'sd100));
    send_pixel(flat(12'd5, 12'd7, 24'sd0));
    drain();
  endtask

  task automatic test_diffuse_directed();
    set_scene(1'b0, 24'd2560, 24'd2560, 24'd25600, 24'd0, 24'd0, 24'd0);
    send_pixel(flat(12'd10, 12'd10, 24'sd0));
    send_pixel('{hd: 24'sd0, hu: 24'sd0, hr: -24'sd512, hl: 24'sd512, hc: 24'sd0,
                 py: 12'd10, px: 12'd10});
    send_pixel('{hd: 24'sh7FFFFF, hu: 24'sh800000, hr: 24'sh800000,
                 hl: 24'sh7FFFFF, hc: 24'sh7FFFFF, py: 12'hFFF, px: 12'hFFF});
    send_pixel('{hd: 24'sh800000, hu: 24'sh7FFFFF, hr: 24'sh7FFFFF,
                 hl: 24'sh800000, hc: 24'sh800000, py: 12'd0, px: 12'hFFF});
    send_pixel(flat(12'd10, 12'd10, 24'sd25600));   // light exactly on the pixel
    send_pixel(flat(12'd10, 12'd10, 24'sd30000));   // light below the surface
    drain();
    write_reg(CFG_UNUSED, 24'hFFFFFF);               // must be ignored
    set_scene(1'b0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'd0, 24'd0, 24'd0);
    send_pixel(flat(12'd0, 12'hFFF, 24'sd0));
    send_pixel(flat(12'hFFF, 12'd0, 24'sh800000));
    drain();
  endtask

  task automatic test_specular_directed();
    // Eye straight above and light straight above: mirror hit.
    set_scene(1'b1, 24'd2560, 24'd2560, 24'd25600, 24'd2560, 24'd2560, 24'd51200);
    send_pixel(flat(12'd10, 12'd10, 24'sd0));
    send_pixel(flat(12'd11, 12'd10, 24'sd0));
    send_pixel(flat(12'd40, 12'd10, 24'sd0));
    send_pixel('{hd: 24'sd0, hu: 24'sd0, hr: 24'sd300, hl: -24'sd300, hc: 24'sd0,
                 py: 12'd10, px: 12'd10});
    send_pixel(flat(12'd10, 12'd10, 24'sd51200));   // eye on the pixel
    send_pixel(flat(12'd10, 12'd10, 24'sd25600));   // light on the pixel
    drain();
    set_scene(1'b1, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    send_pixel(flat(12'hFFF, 12'hFFF, 24'sh7FFFFF));
    send_pixel(flat(12'd0, 12'd0, 24'sh800000));
    drain();
  endtask

  task automatic test_random_scene(int count);
    logic [23:0] lx, ly, ex, ey;
    logic mode;
    mode = $urandom_range(0, 2) != 0;
    if ($urandom_range(0, 4) == 0) begin
      lx = 24'($urandom);
      ly = 24'($urandom);
      set_scene(mode, lx, ly, 24'($urandom), 24'($urandom), 24'($urandom),
                24'($urandom));
    end else begin
      // Light and eye over the same area, placed high: highlights happen.
      lx = 24'($urandom_range(0, 1 << 20));
      ly = 24'($urandom_range(0, 1 << 20));
      ex = 24'(lx + $urandom_range(0, 4096) - 2048);
      ey = 24'(ly + $urandom_range(0, 4096) - 2048);
      set_scene(mode, lx, ly, 24'($urandom_range(1 << 16, 1 << 21)), ex, ey,
                24'($urandom_range(1 << 16, 1 << 21)));
    end
    rx_smooth = $urandom_range(0, 3) == 0;
    for (int i = 0; i < count; i++) begin
      pixel_t p;
      p = rand_pixel();
      if (mode && $urandom_range(0, 1) == 0) begin
        // Aim the pixel near the point below the light.
        p.px = 12'((lx >> 8) + $urandom_range(0, 6) - 3);
        p.py = 12'((ly >> 8) + $urandom_range(0, 6) - 3);
      end
      send_pixel(p);
    end
    rx_smooth = 0;
    drain();
  endtask

  task automatic test_backpressure();
    set_scene(1'b0, 24'd100000, 24'd200000, 24'd300000, 24'd0, 24'd0, 24'd0);
    @(negedge clk);
    hold_off = 400;
    @(posedge clk);
    for (int i = 0; i < 150; i++) send_pixel(rand_pixel(), 1);
    drain();   // sender waits until every shade has come back
  endtask

  initial begin
    spec_mode = 0;
    light_pt = '{0, 0, 0};
    eye_pt = '{0, 0, 0};
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_reset_state();
    test_diffuse_directed();
    test_specular_directed();
    for (int k = 0; k < 8; k++) test_random_scene(110);
    test_backpressure();
    while (shade_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("covered %0d pixel words, %0d shades checked, %0d mirror highlights",
             n_sent, n_checked, n_highlight);
    $display("diffuse and specular scenes incl. extreme positions and stall fill");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
